[hw/rtl/fap_pkg.sv]
// fap_pkg: shared types and constants for the fixed-point atan2 block
// no dependencies
package fap_pkg;
	localparam int YW = 32;
	localparam int AW = 19;
	localparam int MW = 33;

	// constants with 32 fraction bits
	localparam logic [63:0] K_C3 = 64'd199700839;
	localparam logic [63:0] K_C2 = 64'd684249365;
	localparam logic [63:0] K_C1 = 64'd1407129057;
	localparam logic [63:0] K_PI = 64'd13493037705;

	// octant fold flags carried down the pipe
	typedef struct packed {
		logic swap;
		logic xneg;
		logic yneg;
		logic zero;
	} fold_t;
endpackage

[hw/rtl/fap_if.sv]
// fap_if: valid/ready channel interface
// depends on nothing; payload width set by parameter
interface fap_if #(
	parameter int W = 32
);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/fap_div_cell.sv]
// fap_div_cell: one restoring division step as a registered cell
// depends on fap_pkg
module fap_div_cell #(
	parameter int FB = 16,
	parameter bit FIRST = 1'b0
) (
	input  logic                clk,
	input  logic                en,
	input  logic [fap_pkg::MW:0] rem_i,
	input  logic [fap_pkg::MW-1:0] den_i,
	input  logic [FB:0]         quo_i,
	input  fap_pkg::fold_t      fold_i,
	output logic [fap_pkg::MW:0] rem_o,
	output logic [fap_pkg::MW-1:0] den_o,
	output logic [FB:0]         quo_o,
	output fap_pkg::fold_t      fold_o
);
	import fap_pkg::*;
	logic [MW+1:0] sh;
	logic [MW+1:0] df;
	// shift, trial subtract; the first cell takes the integer bit unshifted
	always_comb begin
		sh = FIRST ? {1'b0, rem_i} : {rem_i, 1'b0};
		df = sh - {2'b0, den_i};
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (!df[MW+1]) begin
				rem_o <= df[MW:0];
				quo_o <= {quo_i[FB-1:0], 1'b1};
			end else begin
				rem_o <= sh[MW:0];
				quo_o <= {quo_i[FB-1:0], 1'b0};
			end
			den_o <= den_i;
			fold_o <= fold_i;
		end
	end
endmodule

[hw/rtl/fixed_atan2_polynomial.sv]
// fixed_atan2_polynomial: pipelined fixed-point atan2, Q(FRAC_BITS) in/out
// one word per cycle sustained while the output is not stalled (a chain of
// FRAC_BITS+1 division cells computes the ratio, then a multiplier stage chain)
// output register with skid buffer; the pipe stalls as a whole when the skid is full
// arst_n clears all valid bits; payload registers are not reset
module fixed_atan2_polynomial #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	fap_if.sink   in_ch,
	fap_if.source out_ch
);
	import fap_pkg::*;
	localparam int FB = FRAC_BITS;
	localparam int NC = FB + 1;          // division cells (quotient FB+1 bits)
	localparam int NP = 8;               // polynomial/fold stages
	localparam int NS = NC + 1 + NP;     // total valid stages
	localparam int VW = FB + 4;          // polynomial value width
	localparam int PV = 2 * VW;          // product width

	// rounded constants
	localparam logic signed [VW-1:0] C3 =
		VW'(-$signed((K_C3 + (64'd1 << (31-FB))) >> (32-FB)));
	localparam logic signed [VW-1:0] C2 =
		VW'($signed((K_C2 + (64'd1 << (31-FB))) >> (32-FB)));
	localparam logic signed [VW-1:0] C1 =
		VW'($signed((K_C1 + (64'd1 << (31-FB))) >> (32-FB)));
	localparam logic signed [VW-1:0] PI =
		VW'($signed((K_PI + (64'd1 << (31-FB))) >> (32-FB)));
	localparam logic signed [VW-1:0] PIH = PI >>> 1;

	logic [NS-1:0] v_q;
	logic          en;
	logic          sk_v_q, ov_q;
	logic [AW-1:0] sk_q, od_q;
	logic          room;

	// pipe advances when output stage can take a word
	assign room = !sk_v_q;
	assign en = room;
	assign in_ch.ready = room;

	// stage 0: magnitudes, ordering, fold flags
	logic signed [YW-1:0] yi, xi;
	logic [MW-1:0] ay, ax;
	logic [MW-1:0] mn_s0, mx_s0;
	fold_t fold_s0;
	assign yi = in_ch.data[2*YW-1:YW];
	assign xi = in_ch.data[YW-1:0];
	always_comb begin
		ay = yi[YW-1] ? MW'(-$signed({yi[YW-1], yi})) : MW'({1'b0, yi});
		ax = xi[YW-1] ? MW'(-$signed({xi[YW-1], xi})) : MW'({1'b0, xi});
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mn_s0 <= (ax < ay) ? ax : ay;
			mx_s0 <= (ax < ay) ? ay : ax;
			fold_s0 <= '{swap: ay > ax, xneg: xi[YW-1], yneg: yi[YW-1],
				zero: (ax == '0) && (ay == '0)};
		end
	end

	// division chain: quotient = (mn << FB) / mx; first cell takes mn as remainder
	logic [MW:0]   rem [NC+1];
	logic [MW-1:0] den [NC+1];
	logic [FB:0]   quo [NC+1];
	fold_t         fld [NC+1];
	assign rem[0] = {1'b0, mn_s0};
	assign den[0] = mx_s0;
	assign quo[0] = '0;
	assign fld[0] = fold_s0;

	genvar g;
	generate
		for (g = 0; g < NC; g++) begin : g_div
			fap_div_cell #(.FB(FB), .FIRST(g == 0)) u_cell (
				.clk(clk), .en(en),
				.rem_i(rem[g]), .den_i(den[g]), .quo_i(quo[g]), .fold_i(fld[g]),
				.rem_o(rem[g+1]), .den_o(den[g+1]), .quo_o(quo[g+1]), .fold_o(fld[g+1])
			);
		end
	endgenerate

	// polynomial stages, counted from the quotient
	logic signed [VW-1:0] a_s0, a_s1, a_s2, a_s3;
	logic signed [VW-1:0] sq_s1, sq_s2, sa_s3;
	logic signed [VW-1:0] t_s2, t_s3;
	logic signed [VW-1:0] r_s4, r_s5, r_s6, r_s7;
	fold_t fd_s0, fd_s1, fd_s2, fd_s3, fd_s4, fd_s5, fd_s6;

	function automatic logic signed [VW-1:0] qmul(input logic signed [PV-1:0] p);
		logic [PV-1:0] m;
		logic signed [PV-1:0] r;
		begin
			m = (PV'(1) << FB) - PV'(1);
			if (!p[PV-1]) r = p >>> FB;
			else r = -$signed((PV'(-p) + m) >> FB);
			return VW'(r);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			a_s0 <= $signed(VW'(quo[NC]));
			fd_s0 <= fld[NC];
			// s = a*a
			a_s1 <= a_s0; fd_s1 <= fd_s0;
			sq_s1 <= qmul(a_s0 * a_s0);
			// t = c3*s + c2
			a_s2 <= a_s1; fd_s2 <= fd_s1; sq_s2 <= sq_s1;
			t_s2 <= qmul(C3 * sq_s1) + C2;
			// sa = s*a, t = t*s - c1
			sa_s3 <= qmul(sq_s2 * a_s2);
			a_s3 <= a_s2; fd_s3 <= fd_s2;
			t_s3 <= qmul(t_s2 * sq_s2) - C1;
			fd_s4 <= fd_s3;
			r_s4 <= qmul(t_s3 * sa_s3) + a_s3;
			// octant folds
			fd_s5 <= fd_s4;
			r_s5 <= fd_s4.swap ? PIH - r_s4 : r_s4;
			fd_s6 <= fd_s5;
			r_s6 <= fd_s5.xneg ? PI - r_s5 : r_s5;
			r_s7 <= fd_s6.zero ? '0 : (fd_s6.yneg ? -r_s6 : r_s6);
		end
	end

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[NS-2:0], in_ch.valid};
	end

	// output register with skid
	logic fire;
	assign fire = en && v_q[NS-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0; sk_v_q <= 1'b0;
		end else begin
			if (!ov_q || out_ch.ready) begin
				if (sk_v_q) begin
					ov_q <= 1'b1; sk_v_q <= 1'b0;
				end else ov_q <= fire;
			end else if (fire) sk_v_q <= 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (!ov_q || out_ch.ready) od_q <= sk_v_q ? sk_q : AW'(r_s7);
		else if (fire) sk_q <= AW'(r_s7);
	end
	assign out_ch.valid = ov_q;
	assign out_ch.data = od_q;

	// skid only fills while output is stalled
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(ov_q) && !$past(out_ch.ready))
		else $error("skid filled without stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> !in_ch.ready)
		else $error("input taken with skid full");
	// division leaves a remainder below the divisor
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NC] && !fld[NC].zero |-> rem[NC] < {1'b0, den[NC]})
		else $error("division remainder out of range");
endmodule

[sim/tb_fixed_atan2_polynomial.sv]
// tb_fixed_atan2_polynomial: self-checking bench for the fixed-point atan2 block
// depends on fap_pkg, fap_if and fixed_atan2_polynomial from the rtl folder
// directed table of points then random points, each angle checked against a typed-in value or a local predictor
module tb_fixed_atan2_polynomial;
	import fap_pkg::*;

	localparam int FB = 16;
	localparam int IDLE_PCT = 21;
	localparam int WD_LIMIT = 4000;
	localparam int N_RANDOM = 1330;

	// directed point, with the angle typed in where it is obvious
	typedef struct {
		logic signed [YW-1:0] y;
		logic signed [YW-1:0] x;
		bit known;
		logic [AW-1:0] angle;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	fap_if #(.W(2*YW)) in_ch ();
	fap_if #(.W(AW)) out_ch ();

	logic [AW-1:0] angle_q[$];
	int mismatches = 0;
	int stray = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;

	fixed_atan2_polynomial #(.FRAC_BITS(FB)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #6 clk = ~clk;

	// constant rounded from 32 fraction bits to FB
	function automatic longint frac_const(longint k32);
		return (k32 + (longint'(1) << (31 - FB))) >>> (32 - FB);
	endfunction

	// product scaled back, rounded toward minus infinity
	function automatic longint fmul(longint a, longint b);
		return (a * b) >>> FB;
	endfunction

	// expected angle of one point
	function automatic logic [AW-1:0] atan2_angle(logic signed [YW-1:0] y,
			logic signed [YW-1:0] x);
		longint yy, xx, ay, ax, mn, mx, a, s, t, r, pi_v, pih;
		yy = y;
		xx = x;
		ay = yy < 0 ? -yy : yy;
		ax = xx < 0 ? -xx : xx;
		mn = ax < ay ? ax : ay;
		mx = ax < ay ? ay : ax;
		pi_v = frac_const(longint'(K_PI));
		pih = pi_v >>> 1;
		if (mx == 0)
			return '0;
		a = (mn << FB) / mx;
		s = fmul(a, a);
		t = fmul(-frac_const(longint'(K_C3)), s) + frac_const(longint'(K_C2));
		t = fmul(t, s) - frac_const(longint'(K_C1));
		r = fmul(t, fmul(s, a)) + a;
		if (ay > ax)
			r = pih - r;
		if (xx < 0)
			r = pi_v - r;
		if (yy < 0)
			r = -r;
		return r[AW-1:0];
	endfunction

	// random coordinate: full range, small, or zero; never -2^31
	function automatic logic signed [YW-1:0] rand_coord();
		logic signed [YW-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1, 2: v = $signed($urandom_range(2000)) - 1000;
			3, 4: v = $signed($urandom_range(2000000)) - 1000000;
			default: v = $urandom;
		endcase
		if (v == 32'sh8000_0000)
			v = 32'sh8000_0001;
		return v;
	endfunction

	// offer one word and wait for it to be taken
	task automatic send_point(logic signed [YW-1:0] y, logic signed [YW-1:0] x,
			bit known, logic [AW-1:0] angle);
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= {y, x};
		do @(posedge clk); while (!in_ch.ready);
		angle_q.push_back(known ? angle : atan2_angle(y, x));
	endtask

	// sink side back-pressure
	always @(posedge clk) begin
		out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (angle_q.size() == 0) begin
				stray++;
				if (stray + mismatches <= 10)
					$display("unexpected word angle=%0d", $signed(out_ch.data));
			end else begin
				if (out_ch.data !== angle_q[0]) begin
					mismatches++;
					if (stray + mismatches <= 10)
						$display("angle mismatch: expected %0d got %0d",
							$signed(angle_q[0]), $signed(out_ch.data));
				end
				void'(angle_q.pop_front());
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		point_t dir[$];
		logic signed [YW-1:0] y, x;
		int mode;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;

		// origin, axes, extremes, equal magnitudes, off-diagonal points
		dir.push_back('{32'sd0, 32'sd0, 1, 19'd0});
		dir.push_back('{32'sd0, 32'sd65536, 1, 19'd0});
		dir.push_back('{32'sd0, -32'sd65536, 1, 19'd205887});
		dir.push_back('{32'sd65536, 32'sd0, 1, 19'd102943});
		dir.push_back('{-32'sd65536, 32'sd0, 1, -19'sd102943});
		dir.push_back('{32'sd0, 32'sh7fff_ffff, 1, 19'd0});
		dir.push_back('{32'sd0, -32'sh7fff_ffff, 1, 19'd205887});
		dir.push_back('{32'sh7fff_ffff, 32'sd0, 1, 19'd102943});
		dir.push_back('{-32'sh7fff_ffff, 32'sd0, 1, -19'sd102943});
		dir.push_back('{32'sd65536, 32'sd65536, 0, '0});
		dir.push_back('{-32'sd65536, 32'sd65536, 0, '0});
		dir.push_back('{32'sd65536, -32'sd65536, 0, '0});
		dir.push_back('{-32'sd65536, -32'sd65536, 0, '0});
		dir.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 0, '0});
		dir.push_back('{-32'sh7fff_ffff, -32'sh7fff_ffff, 0, '0});
		dir.push_back('{32'sh7fff_ffff, 32'sd1, 0, '0});
		dir.push_back('{32'sd1, 32'sh7fff_ffff, 0, '0});
		dir.push_back('{-32'sd1, -32'sh7fff_ffff, 0, '0});
		dir.push_back('{32'sd30000, 32'sd70000, 0, '0});
		dir.push_back('{32'sd70000, 32'sd30000, 0, '0});
		dir.push_back('{32'sd70000, -32'sd30000, 0, '0});
		dir.push_back('{-32'sd30000, -32'sd70000, 0, '0});
		dir.push_back('{32'sd1, 32'sd1, 0, '0});
		dir.push_back('{-32'sd1, 32'sd0, 1, -19'sd102943});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i])
			send_point(dir[i].y, dir[i].x, dir[i].known, dir[i].angle);

		// random points, with a stretch free of idling in the middle
		for (int n = 0; n < N_RANDOM; n++) begin
			quiet = (n >= 500 && n < 700);
			mode = $urandom_range(9);
			y = rand_coord();
			x = rand_coord();
			if (mode == 0)
				x = $urandom_range(1) ? y : -y;
			send_point(y, x, 0, '0);
		end
		quiet = 1'b0;
		in_ch.valid <= 1'b0;

		wait (angle_q.size() == 0);
		repeat (2 * (FB + 11)) @(posedge clk);
		if (mismatches == 0 && stray == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
